@@ rtl/mt_pkg.sv @@
// shared constants, types and the tempering function of the mt19937 generator
`default_nettype none

package mt_pkg;

    localparam int unsigned TABLE_DEPTH   = 624;
    localparam int unsigned MIDDLE_OFFSET = 397;
    localparam int unsigned ADDR_W        = $clog2(TABLE_DEPTH + 2);

    typedef logic [ADDR_W-1:0] mt_addr_t;
    typedef logic [31:0]       mt_word_t;

    localparam mt_addr_t LAST_ADDR   = mt_addr_t'(TABLE_DEPTH - 1);
    localparam mt_addr_t DEPTH_POS   = mt_addr_t'(TABLE_DEPTH);
    localparam mt_addr_t UNSEEDED_POS = mt_addr_t'(TABLE_DEPTH + 1);
    localparam mt_addr_t MID_ADDR    = mt_addr_t'(MIDDLE_OFFSET);
    localparam mt_addr_t MID_WRAP    = mt_addr_t'(TABLE_DEPTH - MIDDLE_OFFSET);

    localparam mt_word_t INIT_MULT = 32'd1812433253;
    localparam mt_word_t TWIST_XOR = 32'h9908b0df;
    localparam mt_word_t TEMPER_B  = 32'h9d2c5680;
    localparam mt_word_t TEMPER_C  = 32'hefc60000;
    localparam mt_word_t LOW_BITS  = 32'h7fffffff;

    localparam logic OP_SEED = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    // one write port, two read ports
    typedef struct packed {
        logic     we;
        mt_addr_t waddr;
        mt_word_t wdata;
        mt_addr_t raddr_a;
        mt_addr_t raddr_b;
    } mt_ram_req_t;

    function automatic mt_word_t mt_temper(input mt_word_t w);
        mt_word_t y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

`default_nettype wire

@@ rtl/mersenne_twister_prng.sv @@
// top level of the mt19937 generator: command sequencer around the state table
// A seed transfer (opcode 0) fills the 624-word table with the standard
// initialisation recurrence through a single 32x32 multiplier, so the block
// is busy until the table is full and returns no result. A draw transfer
// (opcode 1) reads the current table word, tempers it and presents it in the
// result register once that is free; the first draw after a seed and every
// 624th draw after it first twist the whole table in place, one word per cycle
// using the two read ports and one write port of the table memory. A draw
// before any seed returns zero with not_seeded set. The block takes one command
// at a time: in_stall is high while a command is in progress, and the result
// register lets the next command enter while a result waits on out_stall.
`default_nettype none

module mersenne_twister_prng (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_stall,
    input  wire              opcode,
    input  mt_pkg::mt_word_t seed_value,
    output logic             out_valid,
    input  wire              out_stall,
    output mt_pkg::mt_word_t random_word,
    output logic             not_seeded
);
    import mt_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SEED_MUL = 3'd1;
    localparam logic [2:0] ST_SEED_ADD = 3'd2;
    localparam logic [2:0] ST_TW_LOAD  = 3'd3;
    localparam logic [2:0] ST_TW_PRIME = 3'd4;
    localparam logic [2:0] ST_TW_RUN   = 3'd5;
    localparam logic [2:0] ST_DRAW     = 3'd6;
    localparam logic [2:0] ST_WAIT     = 3'd7;

    logic [2:0]  state_reg, state_next;
    mt_addr_t    pos_reg, pos_next;
    mt_addr_t    k_reg, k_next;
    logic        unseeded_reg, unseeded_next;
    logic        out_valid_reg, out_valid_next;
    mt_word_t    word_reg, word_next;
    logic        flag_reg, flag_next;
    mt_word_t    prev_reg, prev_next;
    mt_word_t    prod_reg, prod_next;
    mt_word_t    cur_reg, cur_next;

    mt_ram_req_t req;
    mt_word_t    rd_a;
    mt_word_t    rd_b;

    mt_addr_t    kn;
    mt_addr_t    mid_sum;
    mt_word_t    tw_x;
    mt_word_t    tw_v;
    mt_word_t    seed_word;
    logic        in_xfer;
    logic        out_free;

    mt_table_ram u_table (
        .clk  (clk),
        .req  (req),
        .rd_a (rd_a),
        .rd_b (rd_b)
    );

    assign in_xfer  = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign kn       = k_reg + mt_addr_t'(1);
    assign mid_sum  = kn + MID_ADDR;
    assign tw_x     = {cur_reg[31], rd_a[30:0] & LOW_BITS[30:0]};
    assign tw_v     = (tw_x >> 1) ^ (tw_x[0] ? TWIST_XOR : '0);
    assign seed_word = prod_reg + mt_word_t'(k_reg);

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        unseeded_next  = unseeded_reg;
        out_valid_next = out_valid_reg && out_stall;
        word_next      = word_reg;
        flag_next      = flag_reg;
        prev_next      = prev_reg;
        prod_next      = prod_reg;
        cur_next       = cur_reg;

        req.we      = 1'b0;
        req.waddr   = k_reg;
        req.wdata   = seed_word;
        req.raddr_a = (pos_reg < DEPTH_POS) ? pos_reg : '0;
        req.raddr_b = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (opcode == OP_SEED)
                    begin
                        req.we    = 1'b1;
                        req.waddr = '0;
                        req.wdata = seed_value;
                        prev_next = seed_value;
                        k_next    = mt_addr_t'(1);
                        state_next = ST_SEED_MUL;
                    end
                    else if (pos_reg > DEPTH_POS)
                    begin
                        unseeded_next = 1'b1;
                        state_next    = ST_WAIT;
                    end
                    else if (pos_reg == DEPTH_POS)
                    begin
                        unseeded_next = 1'b0;
                        state_next    = ST_TW_LOAD;
                    end
                    else
                    begin
                        unseeded_next = 1'b0;
                        state_next    = ST_DRAW;
                    end
                end
            end
            ST_SEED_MUL:
            begin
                prod_next  = INIT_MULT * (prev_reg ^ (prev_reg >> 30));
                state_next = ST_SEED_ADD;
            end
            ST_SEED_ADD:
            begin
                req.we    = 1'b1;
                req.waddr = k_reg;
                req.wdata = seed_word;
                prev_next = seed_word;
                if (k_reg == LAST_ADDR)
                begin
                    pos_next   = DEPTH_POS;
                    state_next = ST_IDLE;
                end
                else
                begin
                    k_next     = kn;
                    state_next = ST_SEED_MUL;
                end
            end
            ST_TW_LOAD:
            begin
                req.raddr_a = '0;
                state_next  = ST_TW_PRIME;
            end
            ST_TW_PRIME:
            begin
                // old word 0 held aside, reads for step 0 issued
                cur_next    = rd_a;
                req.raddr_a = mt_addr_t'(1);
                req.raddr_b = MID_ADDR;
                k_next      = '0;
                state_next  = ST_TW_RUN;
            end
            ST_TW_RUN:
            begin
                req.we    = 1'b1;
                req.waddr = k_reg;
                req.wdata = rd_b ^ tw_v;
                cur_next  = rd_a;
                // reads for the next step never hit the word written now
                req.raddr_a = (kn >= LAST_ADDR) ? '0 : kn + mt_addr_t'(1);
                req.raddr_b = (mid_sum >= DEPTH_POS) ? kn - MID_WRAP : mid_sum;
                if (k_reg == LAST_ADDR)
                begin
                    pos_next   = '0;
                    state_next = ST_DRAW;
                end
                else
                begin
                    k_next = kn;
                end
            end
            ST_DRAW:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (unseeded_reg)
                    begin
                        word_next = '0;
                        flag_next = 1'b1;
                    end
                    else
                    begin
                        word_next = mt_temper(rd_a);
                        flag_next = 1'b0;
                        pos_next  = pos_reg + mt_addr_t'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= UNSEEDED_POS;
            k_reg         <= '0;
            unseeded_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            k_reg         <= k_next;
            unseeded_reg  <= unseeded_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        flag_reg <= flag_next;
        prev_reg <= prev_next;
        prod_reg <= prod_next;
        cur_reg  <= cur_next;
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign random_word = word_reg;
    assign not_seeded  = flag_reg;

endmodule

`default_nettype wire

@@ rtl/mt_table_ram.sv @@
// state table memory: one write port and two registered read ports
`default_nettype none

module mt_table_ram (
    input  wire                 clk,
    input  mt_pkg::mt_ram_req_t req,
    output mt_pkg::mt_word_t    rd_a,
    output mt_pkg::mt_word_t    rd_b
);
    import mt_pkg::*;

    mt_word_t mem [TABLE_DEPTH];
    mt_word_t rd_a_reg;
    mt_word_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_a_reg <= mem[req.raddr_a];
        rd_b_reg <= mem[req.raddr_b];
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

`default_nettype wire

@@ verif/mt_tb_pkg.sv @@
// scoreboard that predicts mt19937 draw results from the accepted commands
package mt_tb_pkg;

    import mt_pkg::*;

    typedef struct {
        mt_word_t word;
        logic     unseeded;
    } draw_result_t;

    class mt_draw_scoreboard;

        mt_word_t     shadow_table [TABLE_DEPTH];
        int unsigned  shadow_pos;
        draw_result_t pending_draws [$];
        int unsigned  mismatches;
        int unsigned  seeds;
        int unsigned  draws;
        int unsigned  early_draws;
        int unsigned  twists;

        function new();
            shadow_pos = TABLE_DEPTH + 1;
        endfunction

        // called for every accepted command transfer
        function void take_command(logic op, mt_word_t seed);
            mt_word_t    p;
            mt_word_t    x;
            mt_word_t    y;
            int unsigned nxt;
            int unsigned mid;
            if (op == OP_SEED)
            begin
                seeds++;
                shadow_table[0] = seed;
                for (int unsigned i = 1; i < TABLE_DEPTH; i++)
                begin
                    p = shadow_table[i-1];
                    shadow_table[i] = INIT_MULT * (p ^ (p >> 30)) + mt_word_t'(i);
                end
                shadow_pos = TABLE_DEPTH;
                return;
            end
            draws++;
            if (shadow_pos > TABLE_DEPTH)
            begin
                early_draws++;
                pending_draws.push_back('{32'h0, 1'b1});
                return;
            end
            if (shadow_pos == TABLE_DEPTH)
            begin
                // in-place twist of the whole table, in order, as the recurrence needs
                twists++;
                for (int unsigned i = 0; i < TABLE_DEPTH; i++)
                begin
                    nxt = (i + 1) % TABLE_DEPTH;
                    mid = (i + MIDDLE_OFFSET) % TABLE_DEPTH;
                    x = (shadow_table[i] & ~LOW_BITS) | (shadow_table[nxt] & LOW_BITS);
                    y = (x >> 1) ^ (x[0] ? TWIST_XOR : 32'h0);
                    shadow_table[i] = shadow_table[mid] ^ y;
                end
                shadow_pos = 0;
            end
            y = shadow_table[shadow_pos];
            y = y ^ (y >> 11);
            y = y ^ ((y << 7) & TEMPER_B);
            y = y ^ ((y << 15) & TEMPER_C);
            y = y ^ (y >> 18);
            shadow_pos++;
            pending_draws.push_back('{y, 1'b0});
        endfunction

        // called for every accepted result transfer
        function void check_draw(mt_word_t word, logic unseeded);
            draw_result_t want;
            if (pending_draws.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: random_word %h not_seeded %b, none pending",
                             word, unseeded);
                mismatches++;
                return;
            end
            want = pending_draws.pop_front();
            if (word !== want.word || unseeded !== want.unseeded)
            begin
                if (mismatches < 10)
                    $display("mismatch: random_word exp %h got %h, not_seeded exp %b got %b",
                             want.word, word, want.unseeded, unseeded);
                mismatches++;
            end
        endfunction

    endclass

endpackage

@@ verif/testbench.sv @@
// top-level testbench of the mt19937 generator: stimulus, handshakes and verdict
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import mt_pkg::*;
    import mt_tb_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    logic     opcode;
    mt_word_t seed_value;
    logic     out_valid;
    logic     out_stall;
    mt_word_t random_word;
    logic     not_seeded;

    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    bit          hold_request;
    int unsigned hold_left;

    mt_draw_scoreboard sb;

    mersenne_twister_prng u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .seed_value  (seed_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .random_word (random_word),
        .not_seeded  (not_seeded)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver: random stall, or a long hold-off counted here when requested
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = 400;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < sink_idle_pct);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_draw(random_word, not_seeded);
        end
    end

    initial
    begin
        #2ms;
        $display("FAILURE");
        $finish;
    end

    function automatic mt_word_t pick_seed();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_command(logic op, mt_word_t seed);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        seed_value <= seed;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        sb.take_command(op, seed);
    endtask

    task automatic send_random(int unsigned count, int unsigned seed_budget);
        for (int unsigned i = 0; i < count; i++)
        begin
            if (seed_budget > 0 && $urandom_range(0, 19) == 0)
            begin
                seed_budget--;
                send_command(OP_SEED, pick_seed());
            end
            else
                send_command(OP_DRAW, $urandom);
        end
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_draws.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        opcode        = OP_SEED;
        seed_value    = '0;
        hold_request  = 1'b0;
        src_idle_pct  = 19;
        sink_idle_pct = 55;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // draws before any seed must come back flagged
        send_command(OP_DRAW, 32'hffff_ffff);
        send_command(OP_DRAW, 32'h0000_0000);
        send_command(OP_SEED, 32'h0000_0000);
        repeat (3) send_command(OP_DRAW, 32'hffff_ffff);
        send_command(OP_SEED, 32'hffff_ffff);
        repeat (3) send_command(OP_DRAW, 32'h0000_0000);
        send_command(OP_SEED, 32'd5489);
        repeat (4) send_command(OP_DRAW, $urandom);
        // reseed in the middle of a sequence
        send_command(OP_SEED, 32'h8000_0001);
        repeat (2) send_command(OP_DRAW, $urandom);
        wait_for_results();

        send_random(120, 8);
        wait_for_results();

        src_idle_pct  = 55;
        sink_idle_pct = 19;
        send_command(OP_SEED, pick_seed());
        send_random(120, 0);
        wait_for_results();

        // same sequence carries on; receiver holds off first
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_request  = 1'b1;
        send_random(240, 0);
        @(negedge clk);
        in_valid <= 1'b0;

        wait_for_results();
        repeat (1300) @(posedge clk);

        if (sb.pending_draws.size() != 0)
        begin
            $display("%0d draw results never arrived", sb.pending_draws.size());
            sb.mismatches++;
        end
        $display("covered %0d seeds and %0d draws, %0d of them before any seed",
                 sb.seeds, sb.draws, sb.early_draws);
        $display("table twisted %0d times, %0d errors", sb.twists, sb.mismatches);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
